@@ hw/rtl/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int REC_W    = 240 + 160 + 32;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_SEQ    = 3'd1,
    MODE_BIN    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BIN,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/sorted_record_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_record_table_core
// Sorted table of records held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Records (name, type, quantity) live in one RAM of CAPACITY words with a
// registered read. A scan compares one entry per cycle and a shift moves one
// entry per cycle.
// An insert finds its slot, shifts the later entries up and writes the
// record; a remove scans for the key and shifts the later entries down. A
// binary search reads and compares one probe at a time. A read fetches one
// slot. A full table or an unused mode goes straight to the result.
// One request is in flight at a time. The input is ready again on the cycle
// after the result is loaded into the output register, so a waiting result
// does not block the next request. A finished request holds in its last state
// until the previous result has been taken.
module sorted_record_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [47:0] in_key_word3,
  input  logic [63:0] in_kind_word0,
  input  logic [63:0] in_kind_word1,
  input  logic [31:0] in_kind_word2,
  input  logic signed [31:0] in_amount,
  input  logic [5:0]  in_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [5:0]  out_position,
  output logic [6:0]  out_probes,
  output logic [6:0]  out_entry_total,
  output logic [63:0] out_key_word0,
  output logic [63:0] out_key_word1,
  output logic [63:0] out_key_word2,
  output logic [47:0] out_key_word3,
  output logic [63:0] out_kind_word0,
  output logic [63:0] out_kind_word1,
  output logic [31:0] out_kind_word2,
  output logic signed [31:0] out_amount
);
  import srt_pkg::*;

  logic [REC_W-1:0] mem [CAPACITY];
  logic [REC_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  logic [REC_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [2:0]       mode_r, mode_nxt;
  logic [239:0]     key_r, key_nxt;
  logic [REC_W-1:0] rec_r, rec_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;    // entry whose read is pending
  logic [CNT_W:0]   lo_r, lo_nxt, hi_r, hi_nxt; // hi offset by one: hi_r = high+1
  logic [CNT_W-1:0] probes_r, probes_nxt;
  logic             pend_r, pend_nxt;  // read issued last cycle
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [REC_W-1:0] orec_r, orec_nxt;
  logic [CNT_W-1:0] shift_r, shift_nxt; // shift cursor

  // output register
  logic [1:0]       res_st_r, res_st_nxt;
  logic [5:0]       res_pos_r, res_pos_nxt;
  logic [6:0]       res_probes_r, res_probes_nxt;
  logic [6:0]       res_total_r, res_total_nxt;
  logic [REC_W-1:0] res_rec_r, res_rec_nxt;

  logic [239:0] rd_key;
  logic         k_lt, k_eq;
  logic [CNT_W:0] mid;

  assign rd_key = rd_data_r[REC_W-1 -: 240];
  assign k_eq   = (rd_key == key_r);
  assign k_lt   = (rd_key < key_r);
  assign mid    = (lo_r + hi_r - (CNT_W+1)'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    rec_r        <= rec_nxt;
    idx_r        <= idx_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    probes_r     <= probes_nxt;
    st_r         <= st_nxt;
    pos_r        <= pos_nxt;
    orec_r       <= orec_nxt;
    shift_r      <= shift_nxt;
    res_st_r     <= res_st_nxt;
    res_pos_r    <= res_pos_nxt;
    res_probes_r <= res_probes_nxt;
    res_total_r  <= res_total_nxt;
    res_rec_r    <= res_rec_nxt;
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    rec_nxt        = rec_r;
    idx_nxt        = idx_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    probes_nxt     = probes_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r;
    st_nxt         = st_r;
    pos_nxt        = pos_r;
    orec_nxt       = orec_r;
    shift_nxt      = shift_r;
    res_st_nxt     = res_st_r;
    res_pos_nxt    = res_pos_r;
    res_probes_nxt = res_probes_r;
    res_total_nxt  = res_total_r;
    res_rec_nxt    = res_rec_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rec_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          mode_nxt   = in_mode;
          key_nxt    = {in_key_word0, in_key_word1, in_key_word2, in_key_word3};
          rec_nxt    = {in_key_word0, in_key_word1, in_key_word2, in_key_word3,
                        in_kind_word0, in_kind_word1, in_kind_word2, in_amount};
          idx_nxt    = '0;
          probes_nxt = '0;
          st_nxt     = ST_OK;
          pos_nxt    = '0;
          orec_nxt   = '0;
          lo_nxt     = '0;
          hi_nxt     = {1'b0, count_r};
          unique case (in_mode)
            MODE_INSERT: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else if (count_r == '0) begin
                shift_nxt = '0;
                state_nxt = S_SHIFT;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                pend_nxt  = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            MODE_SEQ, MODE_REMOVE: begin
              if (count_r == '0) begin
                st_nxt    = ST_NOTFOUND;
                state_nxt = S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                pend_nxt  = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            MODE_BIN: begin
              state_nxt = S_BIN;
            end
            MODE_READ: begin
              if ({1'b0, in_slot} >= (IDX_W+1)'(count_r)) begin
                st_nxt    = ST_RANGE;
                state_nxt = S_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = in_slot[IDX_W-1:0];
                pos_nxt   = CNT_W'(in_slot);
                pend_nxt  = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        // rd_data_r holds entry idx_r
        if (mode_r == MODE_INSERT) begin
          if (!(k_lt || k_eq)) begin
            // insert at idx_r: shift from count down to idx_r+1
            pos_nxt   = idx_r;
            shift_nxt = count_r;
            state_nxt = S_SHIFT;
          end else if (idx_r + CNT_W'(1) == count_r) begin
            pos_nxt   = count_r;
            shift_nxt = count_r;
            state_nxt = S_SHIFT;
          end else begin
            idx_nxt  = idx_r + CNT_W'(1);
            rd_en    = 1'b1;
            rd_addr  = idx_nxt[IDX_W-1:0];
          end
          if (state_nxt == S_SHIFT && shift_nxt != pos_nxt) begin
            rd_en    = 1'b1;
            rd_addr  = IDX_W'(shift_nxt - CNT_W'(1));
          end
        end else begin
          probes_nxt = idx_r + CNT_W'(1);
          if (k_eq) begin
            pos_nxt  = idx_r;
            orec_nxt = rd_data_r;
            if (mode_r == MODE_REMOVE) begin
              shift_nxt = idx_r;
              if (idx_r + CNT_W'(1) < count_r) begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(idx_r + CNT_W'(1));
              end
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (idx_r + CNT_W'(1) == count_r) begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_nxt[IDX_W-1:0];
          end
        end
      end

      S_SHIFT: begin
        // entry read last cycle (if any) sits in rd_data_r
        if (mode_r == MODE_INSERT) begin
          if (shift_r == pos_r) begin
            wr_en     = 1'b1;
            wr_addr   = pos_r[IDX_W-1:0];
            wr_data   = rec_r;
            count_nxt = count_r + CNT_W'(1);
            orec_nxt  = rec_r;
            state_nxt = S_DONE;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = shift_r[IDX_W-1:0];
            wr_data   = rd_data_r;
            shift_nxt = shift_r - CNT_W'(1);
            if (shift_nxt != pos_r) begin
              rd_en   = 1'b1;
              rd_addr = IDX_W'(shift_nxt - CNT_W'(1));
            end
          end
        end else begin
          if (shift_r + CNT_W'(1) >= count_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_DONE;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = shift_r[IDX_W-1:0];
            wr_data   = rd_data_r;
            shift_nxt = shift_r + CNT_W'(1);
            if (shift_nxt + CNT_W'(1) < count_r) begin
              rd_en   = 1'b1;
              rd_addr = IDX_W'(shift_nxt + CNT_W'(1));
            end
          end
        end
      end

      S_BIN: begin
        if (!pend_r) begin
          if (lo_r >= hi_r) begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_DONE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = mid[IDX_W-1:0];
            idx_nxt  = CNT_W'(mid);
            pend_nxt = 1'b1;
          end
        end else begin
          probes_nxt = probes_r + CNT_W'(1);
          if (k_eq) begin
            pos_nxt   = idx_r;
            orec_nxt  = rd_data_r;
            state_nxt = S_DONE;
          end else if (k_lt) begin
            lo_nxt = {1'b0, idx_r} + (CNT_W+1)'(1);
          end else begin
            hi_nxt = {1'b0, idx_r};
          end
        end
      end

      S_READ: begin
        orec_nxt  = rd_data_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // wait here while the previous result is still held
        if (!out_valid_r || out_ready) begin
          res_st_nxt     = st_r;
          res_pos_nxt    = (st_r == ST_OK) ? pos_r[5:0] : 6'd0;
          res_probes_nxt = 7'(probes_r);
          res_total_nxt  = 7'(count_r);
          res_rec_nxt    = orec_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_st_r;
  assign out_position    = res_pos_r;
  assign out_probes      = res_probes_r;
  assign out_entry_total = res_total_r;
  assign out_key_word0   = res_rec_r[REC_W-1 -: 64];
  assign out_key_word1   = res_rec_r[REC_W-65 -: 64];
  assign out_key_word2   = res_rec_r[REC_W-129 -: 64];
  assign out_key_word3   = res_rec_r[REC_W-193 -: 48];
  assign out_kind_word0  = res_rec_r[191:128];
  assign out_kind_word1  = res_rec_r[127:64];
  assign out_kind_word2  = res_rec_r[63:32];
  assign out_amount      = res_rec_r[31:0];

endmodule

@@ tb/sorted_record_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_record_table_core_tb
// Self-checking bench for the sorted record table.
// ----------------------------------------------------------------------------
// Requests are queued by an initial block and driven by a clocked driver. A
// clocked monitor checks every result field against a table model kept in the
// bench. Sender and receiver idle at random in phases, with one long receiver
// hold-off and a send pause after each phase drains.
module sorted_record_table_core_tb;
  import srt_pkg::*;

  typedef struct packed {
    logic [2:0]         mode;
    logic [63:0]        k0, k1, k2;
    logic [47:0]        k3;
    logic [63:0]        t0, t1;
    logic [31:0]        t2;
    logic signed [31:0] amt;
    logic [5:0]         slot;
  } req_t;

  typedef struct packed {
    logic [63:0]        k0, k1, k2;
    logic [47:0]        k3;
    logic [63:0]        t0, t1;
    logic [31:0]        t2;
    logic signed [31:0] amt;
  } rec_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] probes;
    logic [6:0] total;
    rec_t       rec;
  } resp_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  req_t cur = '0;
  logic [1:0]  o_status;
  logic [5:0]  o_position;
  logic [6:0]  o_probes, o_total;
  logic [63:0] o_k0, o_k1, o_k2;
  logic [47:0] o_k3;
  logic [63:0] o_t0, o_t1;
  logic [31:0] o_t2;
  logic signed [31:0] o_amt;

  sorted_record_table_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(cur.mode), .in_key_word0(cur.k0), .in_key_word1(cur.k1),
    .in_key_word2(cur.k2), .in_key_word3(cur.k3), .in_kind_word0(cur.t0),
    .in_kind_word1(cur.t1), .in_kind_word2(cur.t2), .in_amount(cur.amt),
    .in_slot(cur.slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(o_status), .out_position(o_position), .out_probes(o_probes),
    .out_entry_total(o_total), .out_key_word0(o_k0),
    .out_key_word1(o_k1), .out_key_word2(o_k2),
    .out_key_word3(o_k3), .out_kind_word0(o_t0),
    .out_kind_word1(o_t1), .out_kind_word2(o_t2),
    .out_amount(o_amt)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // table model
  rec_t  tbl[CAPACITY];
  int    count = 0;
  req_t  pending[$];
  resp_t expected[$];
  int    send_idle = 0, recv_idle = 0;
  int    hold_cycles = 0;
  bit    pause_send = 0;
  int    errors = 0;
  int    quiet = 0;
  bit    done = 0;
  // names used by random traffic so searches hit
  rec_t  names[$];

  function automatic int key_cmp(rec_t a, req_t b);
    if ({a.k0, a.k1, a.k2, a.k3} < {b.k0, b.k1, b.k2, b.k3}) return -1;
    if ({a.k0, a.k1, a.k2, a.k3} > {b.k0, b.k1, b.k2, b.k3}) return 1;
    return 0;
  endfunction

  function automatic resp_t apply_request(req_t r);
    resp_t o;
    int p, i, lo, hi, mid, c;
    bit hit;
    o = '0;
    hit = 0;
    case (r.mode)
      MODE_INSERT: begin
        if (count >= CAPACITY) o.status = ST_FULL;
        else begin
          p = 0;
          while (p < count && key_cmp(tbl[p], r) <= 0) p++;
          for (i = count; i > p; i--) tbl[i] = tbl[i-1];
          tbl[p] = {r.k0, r.k1, r.k2, r.k3, r.t0, r.t1, r.t2, r.amt};
          count++;
          o.position = 6'(p);
          o.rec = tbl[p];
        end
      end
      MODE_SEQ, MODE_REMOVE: begin
        for (i = 0; i < count; i++) begin
          o.probes++;
          if (key_cmp(tbl[i], r) == 0) begin
            hit = 1;
            break;
          end
        end
        if (!hit) o.status = ST_NOTFOUND;
        else begin
          o.position = 6'(i);
          o.rec = tbl[i];
          if (r.mode == MODE_REMOVE) begin
            for (; i + 1 < count; i++) tbl[i] = tbl[i+1];
            count--;
          end
        end
      end
      MODE_BIN: begin
        lo = 0;
        hi = count - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          o.probes++;
          c = key_cmp(tbl[mid], r);
          if (c == 0) begin
            hit = 1;
            break;
          end
          if (c < 0) lo = mid + 1;
          else hi = mid - 1;
        end
        if (hit) begin
          o.position = 6'(mid);
          o.rec = tbl[mid];
        end else o.status = ST_NOTFOUND;
      end
      MODE_READ: begin
        if (r.slot < count) begin
          o.position = r.slot;
          o.rec = tbl[r.slot];
        end else o.status = ST_RANGE;
      end
      default: ;
    endcase
    o.total = 7'(count);
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t random_req(logic [2:0] m);
    req_t r;
    rec_t n;
    logic [511:0] raw;
    raw = {rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
           rand64()};
    r = raw[$bits(req_t)-1:0];
    r.mode = m;
    r.slot = 6'($urandom_range(0, 63));
    // keys drawn from only 32 distinct values make duplicates and near misses
    if ($urandom_range(0, 3) != 0) begin
      r.k0 = {3'($urandom_range(0, 7)), 61'd0};
      r.k1 = 64'($urandom_range(0, 1));
      r.k2 = '0;
      r.k3 = $urandom_range(0, 1) ? 48'd0 : 48'hFFFF_FFFF_FFFF;
    end
    if (m != MODE_INSERT && names.size() > 0 && $urandom_range(0, 2) != 0) begin
      n = names[$urandom_range(0, names.size() - 1)];
      {r.k0, r.k1, r.k2, r.k3} = {n.k0, n.k1, n.k2, n.k3};
    end
    if (m == MODE_INSERT)
      names.push_back({r.k0, r.k1, r.k2, r.k3, 160'd0, 32'd0});
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) in_valid <= 0;
    else if (!in_valid || in_ready) begin
      if (in_valid) expected.push_back(apply_request(cur));
      if (pending.size() > 0 && !pause_send &&
          !(send_idle > 0 && $urandom_range(0, 99) < send_idle)) begin
        cur <= pending.pop_front();
        in_valid <= 1;
      end else in_valid <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t got, want;
    if (!rst_n) out_ready <= 0;
    else begin
      if (out_valid && out_ready) begin
        got = {o_status, o_position, o_probes, o_total,
               o_k0, o_k1, o_k2, o_k3, o_t0, o_t1, o_t2, o_amt};
        if (expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: st %0d/%0d pos %0d/%0d pr %0d/%0d tot %0d/%0d rec %h/%h",
                       want.status, got.status, want.position, got.position,
                       want.probes, got.probes, want.total, got.total,
                       want.rec, got.rec);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 0;
      end else out_ready <= !(recv_idle > 0 && $urandom_range(0, 99) < recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
  endtask

  task automatic add_random(int n);
    int i, w;
    logic [2:0] m;
    for (i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < 40) m = MODE_INSERT;
      else if (w < 55) m = MODE_SEQ;
      else if (w < 72) m = MODE_BIN;
      else if (w < 90) m = MODE_REMOVE;
      else if (w < 98) m = MODE_READ;
      else m = 3'($urandom_range(5, 7));
      pending.push_back(random_req(m));
    end
  endtask

  initial begin
    req_t r;
    int ph, i;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    // directed: empty table, extremes, duplicates, unused modes
    for (i = 0; i < 8; i++) pending.push_back(random_req(3'(i)));
    r = '1;
    r.mode = MODE_INSERT;
    pending.push_back(r);
    r = '0;
    pending.push_back(r);
    pending.push_back(r);
    r.amt = 32'sh8000_0000;
    r.k3 = 48'd1;
    pending.push_back(r);
    r.mode = MODE_SEQ;  pending.push_back(r);
    r.mode = MODE_BIN;  pending.push_back(r);
    r = '1; r.mode = MODE_BIN; pending.push_back(r);
    r.mode = MODE_READ; r.slot = 6'd0; pending.push_back(r);
    r.slot = 6'd63; pending.push_back(r);
    r = '0; r.mode = MODE_REMOVE; pending.push_back(r);
    r = '0; r.mode = MODE_READ; r.slot = 6'd2; pending.push_back(r);
    drain();
    // fill to capacity, then hit the full table
    for (i = 0; i < CAPACITY + 2; i++) pending.push_back(random_req(MODE_INSERT));
    for (i = 0; i < 20; i++) pending.push_back(random_req(3'($urandom_range(1, 4))));
    drain();
    for (ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 61 : 16) : 0;
      recv_idle = (ph == 2 || ph == 3) ? (ph == 2 ? 61 : 16) : 0;
      add_random(450);
      if (ph == 0) begin
        repeat (50) @(posedge clk);
        hold_cycles = 600;
      end
      drain();
      pause_send = 1;
      repeat (20) @(posedge clk);
      pause_send = 0;
    end
    done = 1;
    repeat (300) @(posedge clk);
    if (errors == 0 && expected.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
